FILE: design/ppt_pkg.sv
// ppt_pkg: shared types and fixed field widths of the pile top tracker.
// No dependencies; used by ppt_cell and patience_pile_top_tracker.
package ppt_pkg;

    // fixed field widths
    localparam int BLOCK_SIZE_W  = 30;
    localparam int TOWER_COUNT_W = 7;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 8;
    localparam int WIDE_W        = 64;

    // link handed from one cell to the next one up the chain
    typedef struct packed {
        logic any_gt;   // some cell at or below holds a top above the size
        logic occ;      // this cell holds a live pile top
    } ppt_link_t;

endpackage

FILE: design/ppt_cell.sv
// ppt_cell: one pile top slot of the tracker chain.
// Depends on ppt_pkg (ppt_link_t).
module ppt_cell #(
    parameter int SIZE_BITS = 30
) (
    input  logic                  clk,
    input  logic                  upd_en,     // request accepted this cycle
    input  logic                  occ,        // slot index below live count
    input  logic [SIZE_BITS-1:0]  size,       // broadcast block size
    input  ppt_pkg::ppt_link_t    link_in,    // from lower neighbor
    output ppt_pkg::ppt_link_t    link_out,   // to upper neighbor
    output logic                  take        // this slot stores the size
);

    logic [SIZE_BITS-1:0] top_reg;
    logic                 gt;

    assign gt = occ && (top_reg > size);

    // replace the first top above the size, or open the first free slot
    assign take = upd_en && ((gt && !link_in.any_gt) ||
                             (!occ && link_in.occ && !link_in.any_gt));

    assign link_out.any_gt = link_in.any_gt || gt;
    assign link_out.occ    = occ;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            top_reg <= size;
        end
    end

endmodule

FILE: design/patience_pile_top_tracker.sv
// patience_pile_top_tracker: pile count of patience sorting, chain of top cells.
// Depends on ppt_pkg and ppt_cell.
//
// Channel | Dir | tdata (low bit up)          | tuser      | tlast
// s_*     | in  | block_size[29:0], 2'b0 pad  | new_set    | last_block
// m_*     | out | tower_count[6:0], 1'b0 pad  | overflow   | final_res
//
// One request per cycle: the size is broadcast to all MAX_TOWERS cells, each
// compares against its own top and passes an "any greater" flag up the chain,
// so the whole update lands at the accepting edge. The result enters an
// output register at that same edge; s_tready stays high while that register
// is empty or being drained, so a stalled m_tready stalls input after one
// held result. Reset clears the count, overflow flag and output valid; the
// pile tops themselves are never cleared, only the count marks them live.
module patience_pile_top_tracker #(
    parameter int MAX_TOWERS = 64,
    parameter int SIZE_BITS  = 30
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ppt_pkg::S_TDATA_W-1:0]  s_tdata,   // block_size, pad
    input  logic                           s_tuser,   // new_set
    input  logic                           s_tlast,   // last_block
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ppt_pkg::M_TDATA_W-1:0]  m_tdata,   // tower_count, pad
    output logic                           m_tuser,   // overflow
    output logic                           m_tlast    // final_res
);

    localparam int CW = $clog2(MAX_TOWERS + 1);

    // control state
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          out_valid_reg, out_valid_next;
    // output payload
    logic [ppt_pkg::TOWER_COUNT_W-1:0] out_count_reg, out_count_next;
    logic          out_ovf_reg, out_ovf_next;
    logic          out_last_reg, out_last_next;

    logic                      accept;
    logic [CW-1:0]             count_eff;
    logic                      ovf_eff;
    logic                      full;
    logic                      hit;
    logic [SIZE_BITS-1:0]      size;
    logic [ppt_pkg::WIDE_W-1:0] size_wide;
    logic [ppt_pkg::WIDE_W-1:0] count_wide;
    logic [MAX_TOWERS-1:0]     take_vec;
    ppt_pkg::ppt_link_t        links [MAX_TOWERS+1];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // block size masked/extended to the kept width
    assign size_wide = {{(ppt_pkg::WIDE_W - ppt_pkg::BLOCK_SIZE_W){1'b0}},
                        s_tdata[ppt_pkg::BLOCK_SIZE_W-1:0]};
    assign size      = size_wide[SIZE_BITS-1:0];

    // new_set empties the list before this request is handled
    assign count_eff = s_tuser ? '0 : count_reg;
    assign ovf_eff   = s_tuser ? 1'b0 : ovf_reg;
    assign full      = (count_eff == CW'(MAX_TOWERS));

    // bottom of the chain: nothing below, treated as occupied
    assign links[0].any_gt = 1'b0;
    assign links[0].occ    = 1'b1;

    for (genvar i = 0; i < MAX_TOWERS; i++)
    begin : g_cell
        ppt_cell #(
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .clk      (clk),
            .upd_en   (accept),
            .occ      (CW'(i) < count_eff),
            .size     (size),
            .link_in  (links[i]),
            .link_out (links[i+1]),
            .take     (take_vec[i])
        );
    end

    assign hit = links[MAX_TOWERS].any_gt;

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        if (accept)
        begin
            if (hit || full)
            begin
                count_next = count_eff;
            end
            else
            begin
                count_next = count_eff + CW'(1);
            end
            ovf_next       = ovf_eff || (!hit && full);
            out_valid_next = 1'b1;
            out_count_next = count_wide[ppt_pkg::TOWER_COUNT_W-1:0];
            out_ovf_next   = ovf_next;
            out_last_next  = s_tlast;
        end
    end

    assign count_wide = ppt_pkg::WIDE_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ppt_pkg::M_TDATA_W - ppt_pkg::TOWER_COUNT_W){1'b0}}, out_count_reg};
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_last_reg;

    // count never passes capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TOWERS))
        else $error("pile count above capacity");

    // overflow only ever raised with every pile in use
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CW'(MAX_TOWERS)))
        else $error("overflow set while piles remain free");

    // a size lands in at most one cell
    a_one_take: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(take_vec))
        else $error("more than one cell took the size");

    // a new set always starts with exactly one pile
    a_new_set: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser) |=> (count_reg == CW'(1)) && !ovf_reg)
        else $error("new set did not restart at one pile");

endmodule

FILE: tb/patience_pile_top_tracker_tb.sv
`timescale 1ns / 1ps
// patience_pile_top_tracker_tb: self-checking bench for the patience pile counter.
// Depends on ppt_pkg and patience_pile_top_tracker; keeps its own pile model,
// drives directed and random block sets with random idling on both streams.
module patience_pile_top_tracker_tb;

    localparam int BLOCK_SIZE_W  = ppt_pkg::BLOCK_SIZE_W;
    localparam int TOWER_COUNT_W = ppt_pkg::TOWER_COUNT_W;
    localparam int S_TDATA_W     = ppt_pkg::S_TDATA_W;
    localparam int M_TDATA_W     = ppt_pkg::M_TDATA_W;

    localparam int PILE_CAP    = 64;
    localparam int STALL_LIMIT = 4000;   // cycles with no handshake on either side
    localparam logic [BLOCK_SIZE_W-1:0] SIZE_MAX = '1;

    // one expected response: count, sticky overflow, final marker
    typedef struct packed {
        logic [TOWER_COUNT_W-1:0] towers;
        logic                     ovf;
        logic                     fin;
    } tower_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // block_size[29:0], pad[31:30]
    logic                  s_tuser;    // new_set
    logic                  s_tlast;    // last_block
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // tower_count[6:0], pad[7]
    logic                  m_tuser;    // overflow
    logic                  m_tlast;    // final_res

    // pile model state
    logic [BLOCK_SIZE_W-1:0] tops_mirror [PILE_CAP];
    int                      pile_total;
    logic                    overflow_flag;

    tower_result_t towers_due[$];   // responses still owed by the block
    int            error_count;
    int            stall_cycles;
    logic          idle_en;         // random idling on both streams when set

    always #1 clk = ~clk;

    patience_pile_top_tracker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Pile update for one accepted request: find the first top strictly above
    // the size and replace it, else open a new pile, else flag overflow.
    function automatic void place_block(input logic [BLOCK_SIZE_W-1:0] size,
                                        input logic fresh, input logic fin);
        int            pos;
        tower_result_t res;
        if (fresh)
        begin
            pile_total    = 0;
            overflow_flag = 1'b0;
        end
        pos = 0;
        while (pos < pile_total && tops_mirror[pos] <= size)
            pos++;
        if (pos < pile_total)
            tops_mirror[pos] = size;
        else if (pile_total < PILE_CAP)
        begin
            tops_mirror[pile_total] = size;
            pile_total++;
        end
        else
            overflow_flag = 1'b1;
        res.towers = pile_total[TOWER_COUNT_W-1:0];
        res.ovf    = overflow_flag;
        res.fin    = fin;
        towers_due.insert(towers_due.size(), res);
    endfunction

    // Present one request, with optional idle cycles first, and hold it until
    // the block takes it. Valid stays high into the next request.
    task automatic offer_block(input logic [BLOCK_SIZE_W-1:0] size,
                               input logic fresh, input logic fin);
        while (idle_en && $urandom_range(99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, size};
        s_tuser  <= fresh;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        place_block(size, fresh, fin);
    endtask

    // Response side: random back-pressure and field-by-field compare.
    always @(posedge clk)
    begin
        tower_result_t want;
        m_tready <= !(idle_en && $urandom_range(99) < 9);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (towers_due.size() == 0)
            begin
                $display("%0t: unexpected response count=%0d ovf=%0b fin=%0b",
                         $time, m_tdata[TOWER_COUNT_W-1:0], m_tuser, m_tlast);
                error_count++;
            end
            else
            begin
                want = towers_due.pop_front();
                if (m_tdata[TOWER_COUNT_W-1:0] !== want.towers)
                begin
                    $display("%0t: tower_count expected %0d got %0d",
                             $time, want.towers, m_tdata[TOWER_COUNT_W-1:0]);
                    error_count++;
                end
                if (m_tuser !== want.ovf)
                begin
                    $display("%0t: overflow expected %0b got %0b", $time, want.ovf, m_tuser);
                    error_count++;
                end
                if (m_tlast !== want.fin)
                begin
                    $display("%0t: final_res expected %0b got %0b", $time, want.fin, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("** patience_pile_top_tracker: FAILED **");
            $finish;
        end
    end

    // Directed: equal sizes open piles, smaller ones replace, extremes of the
    // size, last_block without new_set keeps the piles, one-item sets.
    task automatic test_basics();
        int k;
        offer_block(30'd100, 1'b0, 1'b0);        // first request straight after reset
        offer_block(30'd100, 1'b0, 1'b0);        // equal top is not greater
        offer_block(30'd50, 1'b0, 1'b0);
        offer_block(30'd0, 1'b0, 1'b0);
        offer_block(SIZE_MAX, 1'b0, 1'b0);
        offer_block(SIZE_MAX, 1'b0, 1'b0);
        offer_block(SIZE_MAX - 1'b1, 1'b0, 1'b1);
        offer_block(30'd7, 1'b0, 1'b0);          // continues after a final marker
        offer_block(SIZE_MAX, 1'b1, 1'b0);
        offer_block(30'd0, 1'b0, 1'b0);
        offer_block(30'd0, 1'b0, 1'b0);
        for (k = 5; k >= 1; k--)                  // strictly decreasing: one tower
            offer_block(BLOCK_SIZE_W'(k), k == 5, k == 1);
        offer_block(30'h2AAA_AAAA, 1'b1, 1'b1);
        offer_block(30'h1555_5555, 1'b1, 1'b1);
    endtask

    // Fill every pile, then force overflow; it must stick through later
    // replacements and clear only on new_set.
    task automatic test_capacity();
        int                      k;
        logic [BLOCK_SIZE_W-1:0] ramp;
        ramp = BLOCK_SIZE_W'($urandom_range(0, 1000));
        for (k = 0; k < PILE_CAP; k++)
        begin
            offer_block(ramp, k == 0, 1'b0);
            ramp = ramp + BLOCK_SIZE_W'($urandom_range(1, 5000));
        end
        offer_block(SIZE_MAX, 1'b0, 1'b0);        // needs pile 65: dropped
        offer_block(30'd0, 1'b0, 1'b0);           // replacement, flag stays
        offer_block(SIZE_MAX, 1'b0, 1'b1);
        offer_block(30'd3, 1'b1, 1'b0);           // new set clears it
        offer_block(30'd2, 1'b0, 1'b1);
    endtask

    // Random sets: mostly well-formed (new_set first, last_block last) with a
    // mix of value shapes; a few long ramps run into capacity; some noise.
    task automatic test_random_sets(input int n_items);
        int                      sent;
        int                      len;
        int                      shape;
        int                      k;
        logic [BLOCK_SIZE_W-1:0] size;
        logic [BLOCK_SIZE_W-1:0] base;
        logic                    fresh;
        logic                    fin;
        sent = 0;
        while (sent < n_items)
        begin
            shape = $urandom_range(9);
            len   = (shape == 0) ? $urandom_range(60, 72) : $urandom_range(1, 30);
            base  = (shape == 0) ? BLOCK_SIZE_W'($urandom_range(0, 1000))
                                 : BLOCK_SIZE_W'($urandom);
            for (k = 0; k < len; k++)
            begin
                if (shape == 0)
                begin
                    base = base + BLOCK_SIZE_W'($urandom_range(1, 1000));
                    size = base;
                end
                else if (shape <= 4)
                    size = BLOCK_SIZE_W'($urandom_range(0, 15));   // many ties
                else if (shape <= 7)
                    size = BLOCK_SIZE_W'($urandom);
                else
                    size = base + BLOCK_SIZE_W'($urandom_range(0, 63));
                fresh = (k == 0);
                fin   = (k == len - 1);
                if ($urandom_range(99) < 8)
                begin
                    fresh = 1'($urandom_range(1));
                    fin   = 1'($urandom_range(1));
                end
                offer_block(size, fresh, fin);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        s_tlast       = 1'b0;
        idle_en       = 1'b1;
        error_count   = 0;
        pile_total    = 0;
        overflow_flag = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_basics();
        test_capacity();
        test_random_sets(250);
        idle_en = 1'b0;            // back-to-back stretch, no idling either side
        test_random_sets(70);
        idle_en = 1'b1;
        test_random_sets(40);

        s_tvalid <= 1'b0;
        while (towers_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("** patience_pile_top_tracker: PASSED **");
        else
            $display("** patience_pile_top_tracker: FAILED **");
        $finish;
    end

endmodule

FILE: patience_pile_top_tracker.f
design/ppt_pkg.sv
design/ppt_cell.sv
design/patience_pile_top_tracker.sv
tb/patience_pile_top_tracker_tb.sv
